>>> design/keyframe_matrix_interpolator_top_defines.svh
// assertion helpers for the keyframe interpolator
`ifndef KEYFRAME_MATRIX_INTERPOLATOR_TOP_DEFINES_SVH
`define KEYFRAME_MATRIX_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define KMI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmi assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define KMI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmi assertion failed");

`endif

>>> design/kmi_pkg.sv
package kmi_pkg;

  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int ELEM_W    = 4;
  localparam int DATA_W    = 32;
  localparam int TIME_W    = 32;
  localparam int KCNT_W    = 5;
  localparam int REM_W     = 35;
  localparam int STEP_W    = 6;
  localparam int RATIO_W   = 16;
  localparam int ARITH_W   = 36;

  localparam logic [OP_W-1:0] OP_KEY_TIME = 2'd0;
  localparam logic [OP_W-1:0] OP_ELEMENT  = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT    = 2'd1;

  localparam logic [STEP_W-1:0] MOD_STEPS   = 6'd32;
  localparam logic [STEP_W-1:0] RATIO_STEPS = 6'd16;

  localparam logic [ELEM_W-1:0] LAST_ELEM = 4'd15;

  typedef struct packed {
    logic              go;
    logic [REM_W-1:0]  rem_init;
    logic [TIME_W-1:0] dividend;
    logic [REM_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [REM_W-1:0]  rem;
    logic [TIME_W-1:0] quo;
  } div_rsp_t;

endpackage

>>> design/keyframe_matrix_interpolator_top.sv
// channel   | direction | signals
// ----------+-----------+---------------------------------------------------------
// request   | in        | start/busy, operation, key_index, element_index,
//           |           | element_value, time_value
// config    | in        | cfg_valid/cfg_ready, cfg_index, cfg_data
// result    | out       | out_valid strobe, out_element_index, out_element_value, last
//
// load requests (key time, matrix element) finish in the cycle they are taken
// a sample holds busy through the modulo on the shared bit-serial divider (skipped for a
// zero cycle length), the key time scan, the segment math, the ratio division (skipped
// when the ratio is 0 or saturates) and the stream of 16 results; the last result shows
// in the first idle cycle
// rst is synchronous and active high; both key stores hold no reset value
// results leave one per cycle on consecutive cycles; the receiver cannot stall
module keyframe_matrix_interpolator_top #(
  parameter int MAX_KEYS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [3:0]  key_index,
  input  logic [3:0]  element_index,
  input  logic signed [31:0] element_value,
  input  logic [31:0] time_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [3:0]  out_element_index,
  output logic signed [31:0] out_element_value,
  output logic        last
);

  localparam int KEY_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int MAT_AW = KEY_W + kmi_pkg::ELEM_W;
  localparam int AW     = kmi_pkg::ARITH_W;
  localparam int PROD_W = 50;

  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(64'sd2147483648);

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_SCAN, S_CALC, S_CHECK, S_DIV, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [kmi_pkg::TIME_W-1:0] cycle_length;
  logic [kmi_pkg::KCNT_W-1:0] key_count;

  // request decode
  logic             accept;
  logic             key_ok;
  logic [KEY_W-1:0] key_addr;
  logic [CNT_W-1:0] n_clamp;

  // sample context
  logic [kmi_pkg::TIME_W-1:0] t;
  logic [CNT_W-1:0]           n_reg;
  logic [KEY_W-1:0]           last_key;

  // scan of key times
  logic [CNT_W-1:0]           scan_addr;
  logic                       scan_issue;
  logic                       rd_valid;
  logic [KEY_W-1:0]           rd_idx;
  logic                       stopped;
  logic                       found;
  logic [KEY_W-1:0]           s_idx;
  logic [kmi_pkg::TIME_W-1:0] ts, tnx, t0, tl;
  logic [kmi_pkg::TIME_W-1:0] time_rdata;

  // segment math
  logic signed [AW-1:0] cyc_s, t_s, ts_s, tnx_s, t0_s, tl_s;
  logic signed [AW-1:0] a_calc, len_calc;
  logic signed [AW-1:0] a_r, len_r;
  logic [KEY_W-1:0]     s_fin, nx_fin, s_r, nx_r;
  logic [kmi_pkg::RATIO_W-1:0] ratio;

  // element stream
  logic [kmi_pkg::ELEM_W-1:0] k;
  logic                       iss_done;
  logic                       out_issue;
  logic [MAT_AW-1:0]          mat_waddr;
  logic [kmi_pkg::DATA_W-1:0] x_rdata, y_rdata;
  logic                       p1_valid, p2_valid, p3_valid;
  logic [kmi_pkg::ELEM_W-1:0] p1_k, p2_k, p3_k;
  logic signed [32:0]         diff2;
  logic signed [31:0]         x2, x3;
  logic signed [PROD_W-1:0]   prod3;
  logic signed [PROD_W-1:0]   sum4;
  logic signed [16:0]         ratio_s;

  kmi_pkg::div_req_t div_req;
  kmi_pkg::div_rsp_t div_rsp;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign key_ok    = (32'(key_index) < MAX_KEYS);
  assign key_addr  = KEY_W'(key_index);
  assign mat_waddr = {key_addr, element_index};

  // key count out of range is clamped to 1..MAX_KEYS
  always_comb begin
    if (key_count == '0) begin
      n_clamp = CNT_W'(1);
    end else if (32'(key_count) > MAX_KEYS) begin
      n_clamp = CNT_W'(MAX_KEYS);
    end else begin
      n_clamp = CNT_W'(key_count);
    end
  end

  kmi_time_mem #(.ADDR_W(KEY_W), .DEPTH(MAX_KEYS)) u_time_mem (
    .clk   (clk),
    .we    (accept && operation == kmi_pkg::OP_KEY_TIME && key_ok),
    .waddr (key_addr),
    .wdata (time_value),
    .raddr (scan_addr[KEY_W-1:0]),
    .rdata (time_rdata)
  );

  kmi_mat_mem #(.ADDR_W(MAT_AW), .DEPTH(MAX_KEYS * 16)) u_mat_mem (
    .clk     (clk),
    .we      (accept && operation == kmi_pkg::OP_ELEMENT && key_ok),
    .waddr   (mat_waddr),
    .wdata   (element_value),
    .raddr_a ({s_r, k}),
    .raddr_b ({nx_r, k}),
    .rdata_a (x_rdata),
    .rdata_b (y_rdata)
  );

  kmi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign scan_issue = (state == S_SCAN) && (scan_addr != n_reg);
  assign out_issue  = (state == S_OUT) && !iss_done;

  // segment offset and length; a zero cycle length means a 2^32 tick loop
  always_comb begin
    cyc_s  = (cycle_length == '0) ? AW'(64'h1_0000_0000) : $signed(AW'(cycle_length));
    t_s    = $signed(AW'(t));
    ts_s   = $signed(AW'(ts));
    tnx_s  = $signed(AW'(tnx));
    t0_s   = $signed(AW'(t0));
    tl_s   = $signed(AW'(tl));
    s_fin  = found ? s_idx : last_key;
    nx_fin = (s_fin == last_key) ? '0 : s_fin + 1'b1;
    // a time before the first key sits on the wrapping segment
    a_calc = found ? (t_s - ts_s) : (t_s + cyc_s - tl_s);
    len_calc = (s_fin == last_key) ? (cyc_s - tl_s + t0_s) : (tnx_s - ts_s);
  end

  // shared divider: modulo at sample start, ratio after the scan
  always_comb begin
    div_req = '0;
    if (state == S_IDLE && accept && operation == kmi_pkg::OP_SAMPLE
        && cycle_length != '0) begin
      div_req.go       = 1'b1;
      div_req.dividend = time_value;
      div_req.divisor  = kmi_pkg::REM_W'(cycle_length);
      div_req.steps    = kmi_pkg::MOD_STEPS;
    end else if (state == S_CHECK && len_r > 0 && a_r > 0 && a_r < len_r) begin
      div_req.go       = 1'b1;
      div_req.rem_init = a_r[kmi_pkg::REM_W-1:0];
      div_req.divisor  = len_r[kmi_pkg::REM_W-1:0];
      div_req.steps    = kmi_pkg::RATIO_STEPS;
    end
  end

  // x + floor((y - x) * ratio / 65536)
  assign ratio_s = $signed({1'b0, ratio});
  assign sum4    = PROD_W'(x3) + (prod3 >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cycle_length <= kmi_pkg::TIME_W'(1);
      key_count    <= kmi_pkg::KCNT_W'(1);
      rd_valid     <= 1'b0;
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
      p3_valid     <= 1'b0;
      out_valid    <= 1'b0;
      last         <= 1'b0;
      iss_done     <= 1'b1;
    end else begin
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kmi_pkg::REG_CYCLE_LENGTH: cycle_length <= cfg_data;
          kmi_pkg::REG_KEY_COUNT:    key_count    <= cfg_data[kmi_pkg::KCNT_W-1:0];
          default: ;
        endcase
      end

      rd_valid  <= scan_issue;
      p1_valid  <= out_issue;
      p2_valid  <= p1_valid;
      p3_valid  <= p2_valid;
      out_valid <= p3_valid;
      last      <= p3_valid && (p3_k == kmi_pkg::LAST_ELEM);

      case (state)
        S_IDLE: begin
          if (accept && operation == kmi_pkg::OP_SAMPLE) begin
            n_reg     <= n_clamp;
            last_key  <= KEY_W'(n_clamp - 1'b1);
            scan_addr <= '0;
            stopped   <= 1'b0;
            found     <= 1'b0;
            s_idx     <= '0;
            if (cycle_length == '0) begin
              t     <= time_value;
              state <= S_SCAN;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (div_rsp.done) begin
            t     <= div_rsp.rem[kmi_pkg::TIME_W-1:0];
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            scan_addr <= scan_addr + 1'b1;
          end
          if (rd_valid) begin
            // segment start is the last key before the first later one
            if (!stopped) begin
              if (t < time_rdata) begin
                stopped <= 1'b1;
                tnx     <= time_rdata;
              end else begin
                s_idx <= rd_idx;
                ts    <= time_rdata;
                found <= 1'b1;
              end
            end
            if (rd_idx == '0) begin
              t0 <= time_rdata;
            end
            if (rd_idx == last_key) begin
              tl    <= time_rdata;
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          a_r   <= a_calc;
          len_r <= len_calc;
          s_r   <= s_fin;
          nx_r  <= nx_fin;
          state <= S_CHECK;
        end
        S_CHECK: begin
          k        <= '0;
          iss_done <= 1'b0;
          if (len_r <= 0 || a_r <= 0) begin
            ratio <= '0;
            state <= S_OUT;
          end else if (a_r >= len_r) begin
            ratio <= '1;
            state <= S_OUT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            ratio <= div_rsp.quo[kmi_pkg::RATIO_W-1:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_issue) begin
            k <= k + 1'b1;
            if (k == kmi_pkg::LAST_ELEM) begin
              iss_done <= 1'b1;
            end
          end
          if (p3_valid && p3_k == kmi_pkg::LAST_ELEM) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    rd_idx <= scan_addr[KEY_W-1:0];
    p1_k   <= k;
    p2_k   <= p1_k;
    p3_k   <= p2_k;
    diff2  <= $signed({y_rdata[31], y_rdata}) - $signed({x_rdata[31], x_rdata});
    x2     <= $signed(x_rdata);
    x3     <= x2;
    prod3  <= diff2 * ratio_s;
    out_element_index <= p3_k;
    if (sum4 > SAT_MAX) begin
      out_element_value <= 32'sh7fff_ffff;
    end else if (sum4 < SAT_MIN) begin
      out_element_value <= 32'sh8000_0000;
    end else begin
      out_element_value <= sum4[31:0];
    end
  end

endmodule

>>> design/kmi_time_mem.sv
module kmi_time_mem #(
  parameter int ADDR_W = 4,
  parameter int DEPTH  = 16
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [kmi_pkg::TIME_W-1:0] wdata,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [kmi_pkg::TIME_W-1:0] rdata
);

  logic [kmi_pkg::TIME_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/kmi_mat_mem.sv
module kmi_mat_mem #(
  parameter int ADDR_W = 8,
  parameter int DEPTH  = 256
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [kmi_pkg::DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0]         raddr_a,
  input  logic [ADDR_W-1:0]         raddr_b,
  output logic [kmi_pkg::DATA_W-1:0] rdata_a,
  output logic [kmi_pkg::DATA_W-1:0] rdata_b
);

  logic [kmi_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> design/kmi_div.sv
module kmi_div (
  input  logic              clk,
  input  logic              rst,
  input  kmi_pkg::div_req_t req,
  output kmi_pkg::div_rsp_t rsp
);

  logic [kmi_pkg::REM_W-1:0]  rem;
  logic [kmi_pkg::TIME_W-1:0] dvd;
  logic [kmi_pkg::REM_W-1:0]  dvs;
  logic [kmi_pkg::STEP_W-1:0] cnt;
  logic                       done;
  logic [kmi_pkg::REM_W:0]    rem2;
  logic [kmi_pkg::REM_W:0]    diff;
  logic                       ge;

  // one restoring step per cycle
  always_comb begin
    rem2 = {rem, dvd[kmi_pkg::TIME_W-1]};
    diff = rem2 - {1'b0, dvs};
    ge   = (rem2 >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        cnt <= req.steps;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == kmi_pkg::STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem <= req.rem_init;
      dvd <= req.dividend;
      dvs <= req.divisor;
    end else if (cnt != '0) begin
      rem <= ge ? diff[kmi_pkg::REM_W-1:0] : rem2[kmi_pkg::REM_W-1:0];
      dvd <= {dvd[kmi_pkg::TIME_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;
  assign rsp.quo  = dvd;

endmodule

>>> design/kmi_checker.sv
`include "keyframe_matrix_interpolator_top_defines.svh"

module kmi_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  operation,
  input logic        out_valid,
  input logic [3:0]  out_element_index,
  input logic        last
);

  // last comes only with the final element
  `KMI_ASSERT_NOW(a_last_final, last, out_valid && out_element_index == 4'd15)
  // a sample's results run on back-to-back cycles in element order
  `KMI_ASSERT_NEXT(a_burst_runs, out_valid && !last, out_valid && out_element_index == $past(out_element_index) + 4'd1)
  // loads complete at once and leave the block idle
  `KMI_ASSERT_NEXT(a_load_idle, start && !busy && operation != kmi_pkg::OP_SAMPLE, !busy)
  // a taken sample keeps the block busy
  `KMI_ASSERT_NEXT(a_sample_busy, start && !busy && operation == kmi_pkg::OP_SAMPLE, busy)

endmodule

bind keyframe_matrix_interpolator_top kmi_checker u_kmi_checker (.*);
